[hdl/cfr_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the checksummed frame receiver.
// -----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned PAYLOAD_LEN_DEFAULT = 16;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned ADDR_W  = 3;

   localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;

   // register index, taken from paddr[2]
   localparam logic REG_HEAD = 1'b0;
   localparam logic REG_TAIL = 1'b1;

   // front to slot: store a matched frame
   typedef struct packed {
      logic               push;
      logic [COUNT_W-1:0] errors;
   } frame_push_type;

   // slot to back: a frame waits
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] errors;
   } slot_status_type;

endpackage : cfr_pkg
`default_nettype wire

[hdl/cfr_front.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// cfr_front
// Receive window: shifts bytes in, keeps a running payload sum and checks
// the candidate frame when the window fills.
// -----------------------------------------------------------------------------
module cfr_front
   import cfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [BYTE_W-1:0]                   rx_byte,
   input  wire logic [BYTE_W-1:0]                   head_byte,
   input  wire logic [BYTE_W-1:0]                   tail_byte,
   output      logic                                window_ready,
   output      frame_push_type                      frame_push,
   output      logic [PAYLOAD_LEN-1:0][BYTE_W-1:0]  frame_bytes
);

   localparam int unsigned FRAME_LEN = PAYLOAD_LEN + 3;
   localparam int unsigned FILL_W    = $clog2(FRAME_LEN);
   localparam int unsigned CKS_POS   = PAYLOAD_LEN + 1;

   logic [FRAME_LEN-1:0][BYTE_W-1:0] window_ff, window_in;
   logic [BYTE_W-1:0]                psum_ff, psum_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [COUNT_W-1:0]               reject_ff, reject_in;
   logic                             at_check;
   logic                             match;

   // newest byte sits at the top, oldest valid byte at FRAME_LEN - fill
   always_comb begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[FRAME_LEN-1] = rx_byte;
      // payload region after the shift covers old positions 2 .. P+1
      psum_in = psum_ff - window_ff[1] + window_ff[PAYLOAD_LEN+1];
   end

   assign at_check = (fill_ff == FILL_W'(FRAME_LEN - 1));
   assign match    = (window_in[0] == head_byte) &&
                     (window_in[FRAME_LEN-1] == tail_byte) &&
                     (window_in[CKS_POS] == psum_in);

   always_comb begin
      fill_in   = fill_ff;
      reject_in = reject_ff;
      if (accept) begin
         if (!at_check) begin
            fill_in = fill_ff + FILL_W'(1);
         end else if (match) begin
            fill_in = '0;
         end else begin
            reject_in = reject_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         psum_ff   <= '0;
         fill_ff   <= '0;
         reject_ff <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         psum_ff   <= psum_in;
         fill_ff   <= fill_in;
         reject_ff <= reject_in;
      end
   end

   always_comb begin
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         frame_bytes[i] = window_in[i+1];
      end
   end

   assign frame_push.push   = accept && at_check && match;
   assign frame_push.errors = reject_ff;
   assign window_ready      = !at_check;

   // a byte that completes no candidate leaves the reject count alone
   assert property (@(posedge clock) disable iff (reset)
      (accept && !at_check) |=> (reject_ff == $past(reject_ff)))
      else $error("reject count moved without a candidate check");

   // the count only moves on an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(reject_ff))
      else $error("reject count moved while idle");

endmodule : cfr_front
`default_nettype wire

[hdl/cfr_slot.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// cfr_slot
// One-frame queue between the receive window and the payload emitter.
// -----------------------------------------------------------------------------
module cfr_slot
   import cfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire frame_push_type                      frame_push,
   input  wire logic [PAYLOAD_LEN-1:0][BYTE_W-1:0]  push_bytes,
   input  wire logic                                take,
   output      slot_status_type                     status,
   output      logic [PAYLOAD_LEN-1:0][BYTE_W-1:0]  slot_bytes
);

   logic                               valid_ff;
   logic [COUNT_W-1:0]                 errors_ff;
   logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frame_push.push) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_push.push) begin
         errors_ff <= frame_push.errors;
         bytes_ff  <= push_bytes;
      end
   end

   assign status.valid  = valid_ff;
   assign status.errors = errors_ff;
   assign slot_bytes    = bytes_ff;

   // never overwrite a waiting frame, never take from an empty slot
   assert property (@(posedge clock) disable iff (reset)
      frame_push.push |-> !valid_ff)
      else $error("frame pushed into an occupied slot");

   assert property (@(posedge clock) disable iff (reset)
      take |-> valid_ff)
      else $error("frame taken from an empty slot");

endmodule : cfr_slot
`default_nettype wire

[hdl/cfr_back.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// cfr_back
// Payload emitter: loads a frame and hands out one payload byte per beat.
// -----------------------------------------------------------------------------
module cfr_back
   import cfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire slot_status_type                     status,
   input  wire logic [PAYLOAD_LEN-1:0][BYTE_W-1:0]  slot_bytes,
   output      logic                                take,
   input  wire logic                                pop,
   output      logic                                empty,
   output      logic [BYTE_W-1:0]                   payload_byte,
   output      logic [POS_W-1:0]                    byte_position,
   output      logic                                last_of_frame,
   output      logic [COUNT_W-1:0]                  error_total
);

   logic                               busy_ff;
   logic [POS_W-1:0]                   pos_ff;
   logic [COUNT_W-1:0]                 errors_ff;
   logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] shift_ff, shift_in;
   logic                               last;
   logic                               beat;

   assign last = (pos_ff == POS_W'(PAYLOAD_LEN - 1));
   assign beat = pop && busy_ff;
   assign take = status.valid && (!busy_ff || (beat && last));

   always_comb begin
      for (int i = 0; i < PAYLOAD_LEN - 1; i++) begin
         shift_in[i] = shift_ff[i+1];
      end
      shift_in[PAYLOAD_LEN-1] = shift_ff[PAYLOAD_LEN-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (take) begin
         busy_ff <= 1'b1;
         pos_ff  <= '0;
      end else if (beat) begin
         busy_ff <= !last;
         pos_ff  <= pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         shift_ff  <= slot_bytes;
         errors_ff <= status.errors;
      end else if (beat) begin
         shift_ff  <= shift_in;
      end
   end

   assign empty         = !busy_ff;
   assign payload_byte  = shift_ff[0];
   assign byte_position = pos_ff;
   assign last_of_frame = last;
   assign error_total   = errors_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < POS_W'(PAYLOAD_LEN)))
      else $error("payload position ran past the frame");

   assert property (@(posedge clock) disable iff (reset)
      take |=> (busy_ff && pos_ff == '0))
      else $error("frame load did not restart at position zero");

   assert property (@(posedge clock) disable iff (reset)
      (beat && !last) |=> (busy_ff && pos_ff == $past(pos_ff) + POS_W'(1)))
      else $error("payload beat did not advance the position");

endmodule : cfr_back
`default_nettype wire

[hdl/checksummed_frame_receiver_core.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// checksummed_frame_receiver_core
// Finds head / payload / checksum / tail frames in a byte stream and emits
// the payload bytes of each good frame with position, last flag and the
// running reject count.
// -----------------------------------------------------------------------------
//   channel   handshake              beat carries
//   -------   --------------------   -----------------------------------------
//   req       push / full            rx_byte
//   rsp       pop / empty            payload_byte, byte_position,
//                                    last_of_frame, error_total
//   csr       psel/penable/pwrite    head_byte at 0x0, tail_byte at 0x4
//
// One received byte is taken per cycle while full is low; the window check runs
// in the same cycle the byte shifts in. A good frame yields PAYLOAD_LEN result
// beats, one per cycle while pop is high, set by the emitter's shift register.
// full rises only when the next byte would complete a candidate frame while
// the one-frame slot still holds an unread frame.
// Reset is synchronous; it clears the window, the running sum and counters.
// Either side may stall for any time without losing a beat.
// -----------------------------------------------------------------------------
module checksummed_frame_receiver_core
   import cfr_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // received bytes
   input  wire logic               push,
   output      logic               full,
   input  wire logic [BYTE_W-1:0]  req_rx_byte,
   // payload results
   output      logic               empty,
   input  wire logic               pop,
   output      logic [BYTE_W-1:0]  rsp_payload_byte,
   output      logic [POS_W-1:0]   rsp_byte_position,
   output      logic               rsp_last_of_frame,
   output      logic [COUNT_W-1:0] rsp_error_total,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [CSR_W-1:0]   pwdata,
   output      logic [CSR_W-1:0]   prdata,
   output      logic               pready
);

   logic [BYTE_W-1:0]                  head_ff;
   logic [BYTE_W-1:0]                  tail_ff;
   logic                               csr_write;
   logic                               accept;
   logic                               window_ready;
   logic                               take;
   frame_push_type                     frame_push;
   slot_status_type                    status;
   logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] frame_bytes;
   logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] slot_bytes;

   // register port: zero wait states, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         tail_ff <= TAIL_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_HEAD: head_ff <= pwdata[BYTE_W-1:0];
            REG_TAIL: tail_ff <= pwdata[BYTE_W-1:0];
            default:  head_ff <= head_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_HEAD: prdata = {{(CSR_W-BYTE_W){1'b0}}, head_ff};
         REG_TAIL: prdata = {{(CSR_W-BYTE_W){1'b0}}, tail_ff};
         default:  prdata = '0;
      endcase
   end

   // hold input only when a candidate check could find the slot busy
   assign full   = !window_ready && status.valid;
   assign accept = push && !full;

   cfr_front #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .head_byte    (head_ff),
      .tail_byte    (tail_ff),
      .window_ready (window_ready),
      .frame_push   (frame_push),
      .frame_bytes  (frame_bytes)
   );

   cfr_slot #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_slot (
      .clock      (clock),
      .reset      (reset),
      .frame_push (frame_push),
      .push_bytes (frame_bytes),
      .take       (take),
      .status     (status),
      .slot_bytes (slot_bytes)
   );

   cfr_back #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .status        (status),
      .slot_bytes    (slot_bytes),
      .take          (take),
      .pop           (pop),
      .empty         (empty),
      .payload_byte  (rsp_payload_byte),
      .byte_position (rsp_byte_position),
      .last_of_frame (rsp_last_of_frame),
      .error_total   (rsp_error_total)
   );

   // a matched frame always finds room in the slot
   assert property (@(posedge clock) disable iff (reset)
      frame_push.push |-> !status.valid)
      else $error("matched frame with no room in the slot");

   // registers change only through a completed write
   assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> ($stable(head_ff) && $stable(tail_ff)))
      else $error("frame marker register changed without a write");

   // a frame left waiting in the slot keeps the input stalled at the check
   assert property (@(posedge clock) disable iff (reset)
      (status.valid && !window_ready) |-> !accept)
      else $error("byte accepted at the check with the slot occupied");

endmodule : checksummed_frame_receiver_core
`default_nettype wire

[dv/tb_checksummed_frame_receiver_core.sv]
// -----------------------------------------------------------------------------
// tb_checksummed_frame_receiver_core
// Self-checking bench for the frame receiver core. Feed head / payload /
// checksum / tail frames, corrupted frames and loose noise bytes under random
// stalls on both channels. Predict every payload beat with a behavioral copy
// of the sliding window, then compare each popped beat field by field.
// -----------------------------------------------------------------------------
module tb_checksummed_frame_receiver_core
   import cfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAYLOAD_LEN  = PAYLOAD_LEN_DEFAULT;
   localparam int unsigned FRAME_LEN    = PAYLOAD_LEN + 3;
   localparam int unsigned DRAIN_CYCLES = 2 * FRAME_LEN + 8;
   localparam int unsigned HOLD_CYCLES  = 300;
   // the random stream runs until this many bytes have gone in overall
   localparam int unsigned RANDOM_BYTES = 120;
   localparam longint     TIMEOUT_NS   = 2_000_000;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic [POS_W-1:0]   position;
      logic               last;
      logic [COUNT_W-1:0] errors;
   } payload_beat_type;

   typedef enum int {
      FAULT_NONE,
      FAULT_HEAD,
      FAULT_PAYLOAD,
      FAULT_CHECKSUM,
      FAULT_TAIL
   } frame_fault_type;

   // DUT connections
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [BYTE_W-1:0]  req_rx_byte = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [BYTE_W-1:0]  rsp_payload_byte;
   logic [POS_W-1:0]   rsp_byte_position;
   logic               rsp_last_of_frame;
   logic [COUNT_W-1:0] rsp_error_total;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [CSR_W-1:0]   pwdata = '0;
   logic [CSR_W-1:0]   prdata;
   logic               pready;

   // predictor state: register copies, window contents, reject counter
   logic [BYTE_W-1:0]  head_value = HEAD_RESET;
   logic [BYTE_W-1:0]  tail_value = TAIL_RESET;
   byte_q_type         window_q;
   logic [COUNT_W-1:0] reject_total = '0;

   // payload beats predicted but not yet popped, oldest first
   payload_beat_type   payload_beats_due[$];

   int unsigned        mismatch_count = 0;
   int unsigned        bytes_offered = 0;
   int unsigned        broken_frames = 0;
   bit                 idle_on = 1'b1;
   bit                 hold_request = 1'b0;

   checksummed_frame_receiver_core #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_error_total   (rsp_error_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Window predictor. Append one accepted byte; once the window holds a whole
   // frame, either emit its payload beats and empty the window, or count a
   // reject and drop the oldest byte so the window slides by one.
   // -------------------------------------------------------------------------
   function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] csum;
      payload_beat_type  beat;
      int unsigned       k;
      window_q.push_back(rx);
      if (window_q.size() < FRAME_LEN) return;
      csum = '0;
      for (k = 1; k <= PAYLOAD_LEN; k++) csum += window_q[k];
      if (window_q[0] != head_value || window_q[FRAME_LEN-1] != tail_value ||
          csum != window_q[PAYLOAD_LEN+1]) begin
         reject_total++;
         void'(window_q.pop_front());
         return;
      end
      for (k = 0; k < PAYLOAD_LEN; k++) begin
         beat.data     = window_q[k+1];
         beat.position = POS_W'(k);
         beat.last     = (k == PAYLOAD_LEN - 1);
         beat.errors   = reject_total;
         payload_beats_due.push_back(beat);
      end
      window_q.delete();
   endfunction

   // -------------------------------------------------------------------------
   // Send one byte. Called right after an edge; an optional idle burst drops
   // push first. push stays high across back-to-back beats so it is never
   // lowered and raised in the same step. The byte counts once full is low.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (full) @(posedge clock);
      absorb_rx_byte(rx);
      bytes_offered++;
   endtask

   // Payload bytes lean toward the extremes and the current head value so
   // that false frame starts show up inside payloads.
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return head_value;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Build head / payload / checksum / tail, spoil one field if asked, send.
   task automatic send_frame(input byte_q_type payload, input frame_fault_type fault);
      byte_q_type        frame;
      logic [BYTE_W-1:0] csum;
      logic [BYTE_W-1:0] spoil;
      int unsigned       k;
      csum = '0;
      foreach (payload[k]) csum += payload[k];
      frame.push_back(head_value);
      foreach (payload[k]) frame.push_back(payload[k]);
      frame.push_back(csum);
      frame.push_back(tail_value);
      spoil = BYTE_W'($urandom_range(1, 255));
      case (fault)
         FAULT_HEAD:     frame[0] ^= spoil;
         FAULT_PAYLOAD:  frame[$urandom_range(1, PAYLOAD_LEN)] ^= spoil;
         FAULT_CHECKSUM: frame[PAYLOAD_LEN+1] ^= spoil;
         FAULT_TAIL:     frame[FRAME_LEN-1] ^= spoil;
         default:        ;
      endcase
      for (k = 0; k < FRAME_LEN; k++) send_byte(frame[k]);
   endtask

   task automatic send_random_frame(input frame_fault_type fault);
      byte_q_type  payload;
      int unsigned k;
      for (k = 0; k < PAYLOAD_LEN; k++) payload.push_back(pick_byte());
      send_frame(payload, fault);
   endtask

   task automatic send_noise(input int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++) send_byte(pick_byte());
   endtask

   // Drop push, wait until every predicted beat is popped, then give the
   // block time to finish any frame check still in flight.
   task automatic settle_block();
      @(negedge clock);
      push <= 1'b0;
      while (payload_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the edge where
   // pready is seen high. Junk in the upper bits must be dropped.
   task automatic write_register(input logic reg_index, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= {BYTE_W'($urandom_range(0, 255)), 16'hBEEF, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_index == REG_HEAD) head_value = value;
      else tail_value = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Two stray bytes ahead of a good frame: the window fills, rejects twice on
   // the head byte, slides into alignment and then accepts. Payload walks the
   // single-bit patterns so every input bit toggles both ways.
   task automatic test_directed_frames();
      byte_q_type payload;
      payload = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                  8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF};
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(payload, FAULT_NONE);
      settle_block();
   endtask

   // Walk head / tail through extreme and equal settings, ending on reset
   // values. Each setting gets a good frame plus a few loose bytes.
   task automatic test_register_settings();
      logic [BYTE_W-1:0] heads [4] = '{8'h00, 8'hFF, 8'h3C, HEAD_RESET};
      logic [BYTE_W-1:0] tails [4] = '{8'hFF, 8'h00, 8'h3C, TAIL_RESET};
      int unsigned       p;
      for (p = 0; p < 4; p++) begin
         settle_block();
         write_register(REG_HEAD, heads[p]);
         write_register(REG_TAIL, tails[p]);
         send_random_frame(FAULT_NONE);
         send_noise($urandom_range(1, 4));
      end
      settle_block();
   endtask

   // Mostly well-formed frames with random content; the rest corrupted
   // frames (cycling head, payload, checksum, tail) and short noise runs.
   task automatic test_random_stream();
      int unsigned pick;
      while (bytes_offered < RANDOM_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            send_random_frame(FAULT_NONE);
         end else if (pick <= 7) begin
            send_random_frame(frame_fault_type'(FAULT_HEAD + broken_frames % 4));
            broken_frames++;
         end else begin
            send_noise($urandom_range(1, 6));
         end
      end
      settle_block();
   endtask

   // Hold pop low for a long stretch while good frames keep coming, so the
   // result side fills and full has to stall the input.
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (3) send_random_frame(FAULT_NONE);
      while (hold_request) @(posedge clock);
      settle_block();
   endtask

   // No idling on either side: back-to-back bytes and beats at full rate.
   task automatic test_full_rate();
      idle_on = 1'b0;
      send_random_frame(FAULT_NONE);
      send_random_frame(FAULT_NONE);
      settle_block();
   endtask

   // -------------------------------------------------------------------------
   // Result side driver: pop changes on the falling edge. A hold request
   // takes priority and is counted out here; otherwise random stall bursts.
   // -------------------------------------------------------------------------
   initial begin : pop_driver
      int unsigned stall;
      int unsigned held_cycles;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
               @(negedge clock);
            pop <= 1'b1;
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            stall = $urandom_range(1, 8);
            repeat (stall - 1) @(negedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: on every popped beat compare all fields against the
   // oldest prediction. Report the first ten problems, count the rest.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : beat_checker
      payload_beat_type seen;
      payload_beat_type want;
      if (!reset && pop && !empty) begin
         seen = '{rsp_payload_byte, rsp_byte_position, rsp_last_of_frame,
                  rsp_error_total};
         if (payload_beats_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected beat data=%h pos=%0d last=%b errors=%0d",
                        $realtime, seen.data, seen.position, seen.last, seen.errors);
            mismatch_count++;
         end else begin
            want = payload_beats_due.pop_front();
            if (seen !== want) begin
               if (mismatch_count < 10)
                  $display("%0t: beat mismatch expected data=%h pos=%0d last=%b errors=%0d, %s",
                           $realtime, want.data, want.position, want.last, want.errors,
                           $sformatf("got data=%h pos=%0d last=%b errors=%0d",
                                     seen.data, seen.position, seen.last, seen.errors));
               mismatch_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: one reset, then the tests in turn, then the verdict.
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_register_settings();
      test_random_stream();
      test_backpressure();
      test_full_rate();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

[checksummed_frame_receiver_core.f]
hdl/cfr_pkg.sv
hdl/cfr_front.sv
hdl/cfr_slot.sv
hdl/cfr_back.sv
hdl/checksummed_frame_receiver_core.sv
dv/tb_checksummed_frame_receiver_core.sv
